>>> hw/rtl/skq_pkg.sv
// ----------------------------------------------------------------------------
// skq_pkg: shared types and codes for the sorted key queue
// Key and item types, operation and status codes, controller phases and the
// command word broadcast from the controller to every cell of the chain.
// ----------------------------------------------------------------------------
package skq_pkg;

    localparam int KEY_W    = 32;
    localparam int ITEM_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [ITEM_W-1:0]       item_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 3'd0,
        OP_REMOVE_HEAD = 3'd1,
        OP_REMOVE_KEY  = 3'd2,
        OP_PREPEND     = 3'd3,
        OP_APPEND      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COMPARE,
        PH_APPLY
    } phase_t;

    localparam key_t RESET_LOWEST  = 32'sd0;
    localparam key_t RESET_HIGHEST = 32'sd100;

    typedef struct packed {
        logic  capture;     // register the compare flags
        logic  ins_sorted;  // insert position by key compare
        logic  at_head;     // insert position is the head
        logic  apply_ins;   // open a slot this cycle
        logic  rm_head;     // removal position is the head
        logic  rm_key;      // removal position by key match
        logic  apply_rm;    // close a slot this cycle
        key_t  key;
        item_t item;
    } cell_cmd_t;

    function automatic logic key_less(key_t a, key_t b);
        return a < b;
    endfunction

endpackage

>>> hw/rtl/skq_req_if.sv
// ----------------------------------------------------------------------------
// skq_req_if: request channel of the sorted key queue
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface skq_req_if;
    import skq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic signed [KEY_W-1:0] key_in;
    logic [ITEM_W-1:0] item_in;

    modport source (output valid, output operation, output key_in, output item_in,
                    input ready);
    modport sink   (input valid, input operation, input key_in, input item_in,
                    output ready);
endinterface

>>> hw/rtl/skq_rsp_if.sv
// ----------------------------------------------------------------------------
// skq_rsp_if: response channel of the sorted key queue
// Valid/ready channel carrying one result item per operation.
// ----------------------------------------------------------------------------
interface skq_rsp_if #(
    parameter int CNT_W = 5
);
    import skq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic signed [KEY_W-1:0] key_out;
    logic [ITEM_W-1:0]   item_out;
    logic                is_empty;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, output status, output key_out, output item_out,
                    output is_empty, output entry_count, input ready);
    modport sink   (input valid, input status, input key_out, input item_out,
                    input is_empty, input entry_count, output ready);
endinterface

>>> hw/rtl/sorted_key_queue.sv
// ----------------------------------------------------------------------------
// sorted_key_queue: sorted priority queue of (key, item) entries
// A row of DEPTH cells holds the entries in position order; a controller
// broadcasts each operation and the cells shift left or right in one step.
// ----------------------------------------------------------------------------
//  channel  role     payload
//  req      sink     operation, key_in, item_in
//  rsp      source   status, key_out, item_out, is_empty, entry_count
//
//  Each item goes through accept, compare in every cell, then apply
//  (find position along the cell chain, shift, write result register).
//  The compare flags are registered in the cells, so compare is a phase of its own.
//  Apply waits while the previous result is still held on rsp.
//  Reset empties the store at once; entries themselves are never cleared.
// ----------------------------------------------------------------------------
module sorted_key_queue #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    skq_req_if.sink   req,
    skq_rsp_if.source rsp
);
    import skq_pkg::*;

    cell_cmd_t        cmd;
    logic [DEPTH-1:0] occupied;
    key_t             cell_key [DEPTH];
    item_t            cell_item [DEPTH];
    logic [DEPTH-1:0] rm_pos;
    logic [DEPTH-1:0] ins_chain;
    logic [DEPTH-1:0] rm_chain;

    skq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .occupied  (occupied),
        .cell_key  (cell_key),
        .cell_item (cell_item),
        .rm_pos    (rm_pos),
        .ins_last  (ins_chain[DEPTH-1]),
        .rm_last   (rm_chain[DEPTH-1])
    );

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        key_t  lk;
        item_t li;
        key_t  rk;
        item_t ri;
        logic  ic;
        logic  rc;

        if (g == 0)
        begin : g_head
            assign lk = '0;
            assign li = '0;
            assign ic = 1'b0;
            assign rc = 1'b0;
        end
        else
        begin : g_body
            assign lk = cell_key[g-1];
            assign li = cell_item[g-1];
            assign ic = ins_chain[g-1];
            assign rc = rm_chain[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign rk = '0;
            assign ri = '0;
        end
        else
        begin : g_inner
            assign rk = cell_key[g+1];
            assign ri = cell_item[g+1];
        end

        skq_cell u_cell (
            .clk           (clk),
            .cmd           (cmd),
            .occupied      (occupied[g]),
            .left_key      (lk),
            .left_item     (li),
            .right_key     (rk),
            .right_item    (ri),
            .ins_chain_in  (ic),
            .rm_chain_in   (rc),
            .ins_chain_out (ins_chain[g]),
            .rm_chain_out  (rm_chain[g]),
            .rm_here       (rm_pos[g]),
            .key           (cell_key[g]),
            .item          (cell_item[g])
        );
    end

endmodule

>>> hw/rtl/skq_cell.sv
// ----------------------------------------------------------------------------
// skq_cell: one storage cell of the sorted key queue
// Holds one (key, item) entry, registers its compare flags against the
// broadcast key, passes the position markers along the chain and shifts
// from its left or right neighbour when a slot opens or closes.
// ----------------------------------------------------------------------------
module skq_cell (
    input  logic               clk,
    input  skq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  skq_pkg::key_t      left_key,
    input  skq_pkg::item_t     left_item,
    input  skq_pkg::key_t      right_key,
    input  skq_pkg::item_t     right_item,
    input  logic               ins_chain_in,
    input  logic               rm_chain_in,
    output logic               ins_chain_out,
    output logic               rm_chain_out,
    output logic               rm_here,
    output skq_pkg::key_t      key,
    output skq_pkg::item_t     item
);
    import skq_pkg::*;

    key_t  key_reg;
    key_t  key_next;
    item_t item_reg;
    item_t item_next;
    logic  lt_reg;
    logic  eq_reg;
    logic  ins_hit;
    logic  rm_hit;
    logic  ins_here;

    always_comb
    begin
        // a free cell always accepts the opening, so append lands at the tail
        ins_hit       = !occupied || cmd.at_head || (cmd.ins_sorted && lt_reg);
        rm_hit        = occupied && (cmd.rm_head || (cmd.rm_key && eq_reg));
        ins_chain_out = ins_chain_in || ins_hit;
        rm_chain_out  = rm_chain_in || rm_hit;
        ins_here      = ins_hit && !ins_chain_in;
        rm_here       = rm_hit && !rm_chain_in;
    end

    always_comb
    begin
        key_next  = key_reg;
        item_next = item_reg;
        if (cmd.apply_ins && ins_chain_out)
        begin
            key_next  = ins_here ? cmd.key : left_key;
            item_next = ins_here ? cmd.item : left_item;
        end
        else if (cmd.apply_rm && rm_chain_out)
        begin
            key_next  = right_key;
            item_next = right_item;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        item_reg <= item_next;
        if (cmd.capture)
        begin
            lt_reg <= key_less(cmd.key, key_reg);
            eq_reg <= (cmd.key == key_reg);
        end
    end

    assign key  = key_reg;
    assign item = item_reg;

endmodule

>>> hw/rtl/skq_ctrl.sv
// ----------------------------------------------------------------------------
// skq_ctrl: controller of the sorted key queue
// Takes one request item, drives the compare and apply phases of the cell
// chain, keeps fill count and key bounds, and holds the result register.
// ----------------------------------------------------------------------------
module skq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    skq_req_if.sink            req,
    skq_rsp_if.source          rsp,
    output skq_pkg::cell_cmd_t cmd,
    output logic [DEPTH-1:0]   occupied,
    input  skq_pkg::key_t      cell_key [DEPTH],
    input  skq_pkg::item_t     cell_item [DEPTH],
    input  logic [DEPTH-1:0]   rm_pos,
    input  logic               ins_last,
    input  logic               rm_last
);
    import skq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    phase_t           state_reg;
    phase_t           state_next;
    op_t              op_reg;
    key_t             arg_key_reg;
    item_t            arg_item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    key_t             lowest_reg;
    key_t             lowest_next;
    key_t             highest_reg;
    key_t             highest_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          out_status_reg;
    status_t          out_status_next;
    key_t             out_key_reg;
    key_t             out_key_next;
    item_t            out_item_reg;
    item_t            out_item_next;
    logic             out_empty_reg;
    logic             out_empty_next;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_count_next;

    logic             can_emit;
    logic             apply_go;
    logic             full;
    key_t             new_key;
    item_t            removed_item;
    key_t             tail_prev_key;
    logic             at_tail;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occupied[i] = (CNT_W'(i) < count_reg);
        end
    end

    assign can_emit = !out_valid_reg || rsp.ready;
    assign apply_go = (state_reg == PH_APPLY) && can_emit;
    assign full     = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        case (op_reg)
            OP_PREPEND: new_key = lowest_reg - 32'sd1;
            OP_APPEND:  new_key = highest_reg + 32'sd1;
            default:    new_key = arg_key_reg;
        endcase
    end

    // one-hot selects over the removal position
    always_comb
    begin
        removed_item  = '0;
        tail_prev_key = '0;
        at_tail       = rm_pos[DEPTH-1];
        for (int i = 0; i < DEPTH; i++)
        begin
            removed_item = removed_item | (cell_item[i] & {ITEM_W{rm_pos[i]}});
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            tail_prev_key = tail_prev_key | (cell_key[i] & {KEY_W{rm_pos[i+1]}});
            at_tail       = at_tail | (rm_pos[i] & ~occupied[i+1]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PH_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = PH_COMPARE;
                end
            end
            PH_COMPARE:
            begin
                state_next = PH_APPLY;
            end
            PH_APPLY:
            begin
                if (can_emit)
                begin
                    state_next = PH_IDLE;
                end
            end
            default:
            begin
                state_next = PH_IDLE;
            end
        endcase
    end

    // outputs, cell command and datapath
    always_comb
    begin
        req.ready       = (state_reg == PH_IDLE);

        cmd             = '0;
        cmd.capture     = (state_reg == PH_COMPARE);
        cmd.ins_sorted  = (op_reg == OP_INSERT);
        cmd.at_head     = (op_reg == OP_PREPEND);
        cmd.rm_head     = (op_reg == OP_REMOVE_HEAD);
        cmd.rm_key      = (op_reg == OP_REMOVE_KEY);
        cmd.key         = new_key;
        cmd.item        = arg_item_reg;

        count_next      = count_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_item_next   = out_item_reg;
        out_empty_next  = out_empty_reg;
        out_count_next  = out_count_reg;

        if (apply_go)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STS_OK;
            out_key_next    = '0;
            out_item_next   = '0;
            case (op_reg)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        out_status_next = STS_FULL;
                    end
                    else
                    begin
                        cmd.apply_ins = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        out_key_next  = arg_key_reg;
                        if (key_less(highest_reg, arg_key_reg))
                        begin
                            highest_next = arg_key_reg;
                        end
                        else if (key_less(arg_key_reg, lowest_reg))
                        begin
                            lowest_next = arg_key_reg;
                        end
                    end
                end
                OP_REMOVE_HEAD:
                begin
                    if (count_reg == '0)
                    begin
                        out_status_next = STS_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.apply_rm  = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        out_key_next  = cell_key[0];
                        out_item_next = cell_item[0];
                        if (count_reg == CNT_W'(1))
                        begin
                            lowest_next  = RESET_LOWEST;
                            highest_next = RESET_HIGHEST;
                        end
                        else
                        begin
                            lowest_next = cell_key[1];
                        end
                    end
                end
                OP_REMOVE_KEY:
                begin
                    if (!rm_last)
                    begin
                        out_status_next = STS_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.apply_rm  = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        out_key_next  = arg_key_reg;
                        out_item_next = removed_item;
                        if (count_reg == CNT_W'(1))
                        begin
                            lowest_next  = RESET_LOWEST;
                            highest_next = RESET_HIGHEST;
                        end
                        else if (rm_pos[0])
                        begin
                            lowest_next = cell_key[1];
                        end
                        else if (at_tail)
                        begin
                            highest_next = tail_prev_key;
                        end
                    end
                end
                OP_PREPEND:
                begin
                    if (full)
                    begin
                        out_status_next = STS_FULL;
                    end
                    else
                    begin
                        cmd.apply_ins = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        lowest_next   = new_key;
                        out_key_next  = new_key;
                    end
                end
                OP_APPEND:
                begin
                    if (full)
                    begin
                        out_status_next = STS_FULL;
                    end
                    else
                    begin
                        cmd.apply_ins = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        highest_next  = new_key;
                        out_key_next  = new_key;
                    end
                end
                default:
                begin
                    out_status_next = STS_OK;
                end
            endcase
            out_empty_next = (count_next == '0);
            out_count_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_IDLE;
            count_reg     <= '0;
            lowest_reg    <= RESET_LOWEST;
            highest_reg   <= RESET_HIGHEST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lowest_reg    <= lowest_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg       <= op_t'(req.operation);
            arg_key_reg  <= req.key_in;
            arg_item_reg <= req.item_in;
        end
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_item_reg   <= out_item_next;
        out_empty_reg  <= out_empty_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.item_out    = out_item_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.entry_count = out_count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_bounds_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> lowest_reg == RESET_LOWEST && highest_reg == RESET_HIGHEST)
        else $error("empty store with bounds not restored");

    // compare flags are only fresh once the compare cycle has passed
    a_single_removal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == PH_APPLY |-> $onehot0(rm_pos))
        else $error("more than one removal position in chain");

    a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply_ins |-> ins_last)
        else $error("insert applied with no slot found");

    a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != PH_APPLY |=> $stable(count_reg))
        else $error("fill count changed outside apply phase");

endmodule

>>> tb/sv/skq_check_pkg.sv
// ----------------------------------------------------------------------------
// skq_check_pkg: result predictor and checker for the sorted key queue
// Keeps its own copy of the held entries and the running key bounds, works
// out the result of each accepted request and checks results in order.
// ----------------------------------------------------------------------------
package skq_check_pkg;
    import skq_pkg::*;

    typedef struct {
        status_t     status;
        key_t        key;
        item_t       item;
        logic        is_empty;
        logic [15:0] count;
    } outcome_t;

    class skq_scoreboard;
        int       capacity;
        key_t     held_keys[$];
        item_t    held_items[$];
        key_t     lowest;
        key_t     highest;
        outcome_t awaited[$];
        int       errors;

        function new(int depth);
            capacity = depth;
            errors = 0;
            reset_bounds();
        endfunction

        function void reset_bounds();
            lowest = RESET_LOWEST;
            highest = RESET_HIGHEST;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted request to the held entries and queue its result.
        function void note_request(logic [OP_W-1:0] op, key_t key, item_t item);
            outcome_t res;
            int       pos;
            int       n;
            res.status = STS_OK;
            res.key = '0;
            res.item = '0;
            n = held_keys.size();
            case (op)
                OP_INSERT:
                begin
                    if (n >= capacity)
                    begin
                        res.status = STS_FULL;
                    end
                    else
                    begin
                        if (highest < key)
                            highest = key;
                        else if (key < lowest)
                            lowest = key;
                        // equal keys stay behind the ones already held
                        pos = 0;
                        while (pos < n && !(key < held_keys[pos]))
                            pos++;
                        held_keys.insert(pos, key);
                        held_items.insert(pos, item);
                        res.key = key;
                    end
                end
                OP_REMOVE_HEAD:
                begin
                    if (n == 0)
                    begin
                        res.status = STS_NOT_FOUND;
                    end
                    else
                    begin
                        res.key = held_keys.pop_front();
                        res.item = held_items.pop_front();
                        if (held_keys.size() == 0)
                            reset_bounds();
                        else
                            lowest = held_keys[0];
                    end
                end
                OP_REMOVE_KEY:
                begin
                    pos = 0;
                    while (pos < n && held_keys[pos] !== key)
                        pos++;
                    if (pos == n)
                    begin
                        res.status = STS_NOT_FOUND;
                    end
                    else
                    begin
                        res.key = key;
                        res.item = held_items[pos];
                        held_keys.delete(pos);
                        held_items.delete(pos);
                        if (n == 1)
                            reset_bounds();
                        else if (pos == 0)
                            lowest = held_keys[0];
                        else if (pos == n - 1)
                            highest = held_keys[n - 2];
                    end
                end
                OP_PREPEND:
                begin
                    if (n >= capacity)
                    begin
                        res.status = STS_FULL;
                    end
                    else
                    begin
                        lowest = lowest - 1;
                        held_keys.push_front(lowest);
                        held_items.push_front(item);
                        res.key = lowest;
                    end
                end
                OP_APPEND:
                begin
                    if (n >= capacity)
                    begin
                        res.status = STS_FULL;
                    end
                    else
                    begin
                        highest = highest + 1;
                        held_keys.push_back(highest);
                        held_items.push_back(item);
                        res.key = highest;
                    end
                end
                default:
                begin
                    // unknown codes leave everything as it is
                end
            endcase
            res.is_empty = (held_keys.size() == 0);
            res.count = 16'(held_keys.size());
            awaited.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, key_t key, item_t item,
                                   logic is_empty, logic [15:0] count);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                $error("result with no request outstanding: status %0d key %0d", status, key);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (key !== want.key)
            begin
                $error("key_out: expected %0d, actual %0d", want.key, key);
                errors++;
            end
            if (item !== want.item)
            begin
                $error("item_out: expected %h, actual %h", want.item, item);
                errors++;
            end
            if (is_empty !== want.is_empty)
            begin
                $error("is_empty: expected %0b, actual %0b", want.is_empty, is_empty);
                errors++;
            end
            if (count !== want.count)
            begin
                $error("entry_count: expected %0d, actual %0d", want.count, count);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> tb/sv/sorted_key_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_key_queue_test: self-checking bench for the sorted key queue
// Directed requests cover the empty store, key extremes, wrapping bounds,
// equal keys and unknown codes; random fill and drain phases follow,
// with random gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module sorted_key_queue_test;
    import skq_pkg::*;
    import skq_check_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASE_ITEMS  = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 16;
    localparam int OP_CODES     = 1 << OP_W;

    logic          clk;
    logic          rst_n;
    logic          steady;
    int            cycles = 0;
    skq_scoreboard board;

    skq_req_if                  req_ch ();
    skq_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

    sorted_key_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // result side: check accepted items, stall at random, guard the run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.status, rsp_ch.key_out, rsp_ch.item_out,
                                   rsp_ch.is_empty, 16'(rsp_ch.entry_count));
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic send_op(input logic [OP_W-1:0] op, input key_t key, input item_t item);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key_in    <= key;
        req_ch.item_in   <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(op, key, item);
    endtask

    // hold the request side until every result is back
    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    function automatic key_t pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return key_t'($urandom_range(0, 8)) - 4;
        else if (roll < 60)
            return $urandom_range(0, 1) ? key_t'(32'h7fff_ffff - $urandom_range(0, 2))
                                        : key_t'(32'h8000_0000 + $urandom_range(0, 2));
        else
            return key_t'($urandom());
    endfunction

    function automatic key_t pick_held_key();
        if (board.held_keys.size() == 0 || $urandom_range(0, 99) < 20)
            return pick_key();
        return board.held_keys[$urandom_range(0, board.held_keys.size() - 1)];
    endfunction

    initial
    begin
        int               n;
        int               roll;
        bit               filling;
        logic [OP_W-1:0]  op;
        key_t             key;

        rst_n            = 1'b0;
        steady           = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.key_in    = '0;
        req_ch.item_in   = '0;
        rsp_ch.ready     = 1'b0;
        board = new(DEPTH);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // removals from an empty store
        send_op(OP_REMOVE_HEAD, '0, '0);
        send_op(OP_REMOVE_KEY, '0, 32'hffff_ffff);
        // key extremes and wrapping bounds
        send_op(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_op(OP_APPEND, '0, 32'h0000_0000);
        send_op(OP_INSERT, 32'h8000_0000, 32'ha5a5_5a5a);
        send_op(OP_PREPEND, '0, 32'h5a5a_a5a5);
        // equal keys keep arrival order
        send_op(OP_INSERT, 32'sd5, 32'h0000_0001);
        send_op(OP_INSERT, 32'sd5, 32'h0000_0002);
        // removal by key at head, middle, tail, and a miss
        send_op(OP_REMOVE_KEY, 32'sd5, '0);
        send_op(OP_REMOVE_KEY, 32'h8000_0000, '0);
        send_op(OP_REMOVE_KEY, 32'h8000_0000, '0);
        send_op(OP_REMOVE_KEY, 32'sd12345, '0);
        for (n = OP_APPEND + 1; n < OP_CODES; n++)
            send_op(OP_W'(n), key_t'($urandom()), $urandom());
        while (board.held_keys.size() != 0)
            send_op(OP_REMOVE_HEAD, key_t'($urandom()), $urandom());
        // bounds restored once empty
        send_op(OP_APPEND, '0, 32'h1234_5678);
        send_op(OP_PREPEND, '0, 32'h8765_4321);
        send_op(OP_INSERT, -32'sd1, 32'h0f0f_0f0f);
        send_op(OP_REMOVE_KEY, 32'sd101, '0);
        send_op(OP_REMOVE_HEAD, '0, '0);
        settle();

        filling = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
                filling = !filling;
            steady = (n >= 700 && n < 1000);
            if (n % 150 == 149)
                settle();
            roll = $urandom_range(0, 99);
            key = pick_key();
            if (filling)
            begin
                if (roll < 50)
                    op = OP_INSERT;
                else if (roll < 63)
                    op = OP_PREPEND;
                else if (roll < 76)
                    op = OP_APPEND;
                else if (roll < 86)
                    op = OP_REMOVE_HEAD;
                else if (roll < 95)
                    op = OP_REMOVE_KEY;
                else
                    op = OP_W'($urandom_range(OP_APPEND + 1, OP_CODES - 1));
            end
            else
            begin
                if (roll < 40)
                    op = OP_REMOVE_HEAD;
                else if (roll < 80)
                    op = OP_REMOVE_KEY;
                else if (roll < 92)
                    op = OP_INSERT;
                else if (roll < 94)
                    op = OP_PREPEND;
                else if (roll < 96)
                    op = OP_APPEND;
                else
                    op = OP_W'($urandom_range(OP_APPEND + 1, OP_CODES - 1));
            end
            if (op == OP_REMOVE_KEY)
                key = pick_held_key();
            send_op(op, key, $urandom());
        end
        steady = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
